// File: hdl/slfo_pkg.sv
// shared types and constants for the sine lfo amplitude modulator
package slfo_pkg;

  localparam int SMP_W  = 24;
  localparam int SINE_W = 15;
  localparam int DEPTH_W = 16;
  localparam int GAIN_W = DEPTH_W + SINE_W + 2;
  localparam int PHASE_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 2'd2;

  localparam logic [DEPTH_W-1:0] MOD_DEPTH_RST = 16'd32768;
  localparam logic [CHAN_W-1:0]  ACTIVE_CH_RST = 2'd2;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_ch1;
    logic signed [SMP_W-1:0] sample_ch0;
  } in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] out_ch1;
    logic signed [SMP_W-1:0] out_ch0;
  } out_t;

endpackage

// File: hdl/slfo_rom.sv
// quarter-wave sine rom, contents built at elaboration, registered read
module slfo_rom #(
  parameter int ADDR_BITS = 10
) (
  input  logic                           clk,
  input  logic [ADDR_BITS:0]             addr,
  output logic [slfo_pkg::SINE_W-1:0]    data_r
);
  import slfo_pkg::*;

  localparam int DEPTH = (1 << ADDR_BITS) + 1;
  localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;

  typedef logic [SINE_W-1:0] rom_arr_t [DEPTH];

  function automatic logic [SINE_W-1:0] sine_entry(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x = (64'(k) * HALF_PI_Q30) >> ADDR_BITS;
    x2 = (x * x) >> 30;
    sum = signed'(x);
    term = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - signed'(term);
    r = (sum + 64'sd16384) >>> 15;
    if (r < 0) begin
      r = 0;
    end
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return r[SINE_W-1:0];
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t t;
    for (int k = 0; k < DEPTH; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  always_ff @(posedge clk) begin
    data_r <= ROM[addr];
  end

endmodule

// File: hdl/slfo_lane.sv
// one channel lane: gain times sample, round half up and saturate to 24 bits
module slfo_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [slfo_pkg::GAIN_W-1:0]  gain,
  input  logic signed [slfo_pkg::SMP_W-1:0]   sample,
  output logic signed [slfo_pkg::SMP_W-1:0]   result
);
  import slfo_pkg::*;

  localparam int PROD_W = GAIN_W + SMP_W;
  localparam int Q_W = PROD_W + 1 - 30;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W:0]   biased;
  logic signed [Q_W-1:0]    q;
  logic                     in_range;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= gain * sample;
    end
  end

  always_comb begin
    biased = {prod_r[PROD_W-1], prod_r} + (PROD_W+1)'(1 << 29);
    q = biased[PROD_W:30];
    in_range = (q[Q_W-1:SMP_W-1] == '0) || (q[Q_W-1:SMP_W-1] == '1);
    if (in_range) begin
      result = q[SMP_W-1:0];
    end else if (q[Q_W-1]) begin
      result = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

endmodule

// File: hdl/sine_lfo_amplitude_modulator_unit.sv
// top level of the sine lfo tremolo: phase accumulator, sine lookup, gain, two lanes, merge
//
//   channel | ports                          | transfer when
//   --------+--------------------------------+----------------------------
//   input   | in_valid, in_ready, in_data    | in_valid && in_ready
//   output  | out_valid, out_ready, out_data | out_valid && out_ready
//   config  | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// a frame passes from input transfer to a valid result through rom read, gain multiply,
// lane multiply, round/saturate into the output register
// the next frame is taken in the cycle its predecessor loads the output register,
// so a new frame is not accepted before its predecessor reaches the output stage
// a stalled output holds the last stage and drops in_ready until out_ready frees the slot
// synchronous reset clears phase, step and valid/state flags, presets depth and channels
module sine_lfo_amplitude_modulator_unit #(
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  slfo_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output slfo_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [slfo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slfo_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import slfo_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ROM, S_GAIN, S_MUL, S_OUT} state_t;

  state_t                     state_r;
  logic [PHASE_W-1:0]         phase_r;
  logic [PHASE_W-1:0]         phase_nxt;
  logic [PHASE_W-1:0]         step_r;
  logic [DEPTH_W-1:0]         depth_r;
  logic [CHAN_W-1:0]          active_r;
  logic [SINE_ADDR_BITS:0]    rom_idx_r;
  logic [SINE_ADDR_BITS:0]    rom_idx_nxt;
  logic [SINE_ADDR_BITS-1:0]  sine_a;
  logic                       neg_r;
  in_t                        smp_r;
  logic [SINE_W-1:0]          rom_data_r;
  logic signed [SINE_W:0]     sine_val;
  logic signed [GAIN_W-1:0]   gain_r;
  logic signed [SMP_W-1:0]    lane0_res;
  logic signed [SMP_W-1:0]    lane1_res;
  logic                       lane_en;
  out_t                       out_data_r;
  out_t                       out_nxt;
  logic                       out_valid_r;
  logic                       out_free;
  logic                       load_out;
  logic                       in_xfer;

  assign out_free  = !out_valid_r || out_ready;
  assign load_out  = (state_r == S_OUT) && out_free;
  assign in_ready  = (state_r == S_IDLE) || load_out;
  assign in_xfer   = in_valid && in_ready;
  assign lane_en   = (state_r == S_MUL);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign phase_nxt = phase_r + step_r;
  assign sine_a    = phase_r[PHASE_W-3 -: SINE_ADDR_BITS];
  assign rom_idx_nxt = phase_r[PHASE_W-2]
                     ? ({1'b1, {SINE_ADDR_BITS{1'b0}}} - {1'b0, sine_a})
                     : {1'b0, sine_a};

  // quadrants 2 and 3 negate
  assign sine_val = neg_r ? -$signed({1'b0, rom_data_r}) : $signed({1'b0, rom_data_r});

  slfo_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk    (clk),
    .addr   (rom_idx_r),
    .data_r (rom_data_r)
  );

  slfo_lane u_lane0 (
    .clk    (clk),
    .en     (lane_en),
    .gain   (gain_r),
    .sample (smp_r.sample_ch0),
    .result (lane0_res)
  );

  slfo_lane u_lane1 (
    .clk    (clk),
    .en     (lane_en),
    .gain   (gain_r),
    .sample (smp_r.sample_ch1),
    .result (lane1_res)
  );

  // merge: inactive channels read zero, a count of three acts as two
  always_comb begin
    out_nxt.out_ch0 = (active_r != '0) ? lane0_res : '0;
    out_nxt.out_ch1 = active_r[1] ? lane1_res : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      step_r      <= '0;
      depth_r     <= MOD_DEPTH_RST;
      active_r    <= ACTIVE_CH_RST;
    end else begin
      if (out_valid_r && out_ready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_ROM;
          end
        end
        S_ROM:  state_r <= S_GAIN;
        S_GAIN: begin
          gain_r  <= $signed({1'b0, depth_r}) * sine_val;
          state_r <= S_MUL;
        end
        S_MUL:  state_r <= S_OUT;
        S_OUT: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            out_data_r  <= out_nxt;
            state_r     <= in_xfer ? S_ROM : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (in_xfer) begin
        phase_r   <= phase_nxt;
        rom_idx_r <= rom_idx_nxt;
        neg_r     <= phase_r[PHASE_W-1];
        smp_r     <= in_data;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_STEP:      step_r   <= cfg_wdata[PHASE_W-1:0];
          REG_MOD_DEPTH:       depth_r  <= cfg_wdata[DEPTH_W-1:0];
          REG_ACTIVE_CHANNELS: active_r <= cfg_wdata[CHAN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> phase_r == $past(phase_r + step_r))
    else $error("phase did not advance by step on input transfer");

  a_out_from_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result became valid outside the output stage");

  a_ch1_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && !active_r[1]) |=> out_data_r.out_ch1 == '0)
    else $error("inactive channel 1 not zero");

  a_ch0_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && active_r == '0) |=> out_data_r.out_ch0 == '0)
    else $error("inactive channel 0 not zero");

endmodule
